FILE: hw/rtl/gbc_pkg.sv
// ============================================================================
// gbc_pkg
// Shared constants, letter class codes and helpers for the Gronsfeld byte
// cipher unit.
// ============================================================================
package gbc_pkg;

    localparam int KEY_DIGITS_MAX = 10;
    localparam int KEY_WIDTH      = 4 * KEY_DIGITS_MAX;
    localparam int POS_WIDTH      = 4;
    localparam int LEN_WIDTH      = 4;
    localparam int CFG_ADDR_WIDTH = 2;

    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_DECRYPT_MODE = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_KEY_DIGITS   = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_KEY_LENGTH   = 2'd2;

    localparam logic [LEN_WIDTH-1:0] KEY_LENGTH_RESET = 4'd1;
    localparam logic [LEN_WIDTH-1:0] KEY_LENGTH_MAX   = LEN_WIDTH'(KEY_DIGITS_MAX);

    localparam logic [4:0] LATIN_SPAN = 5'd26;

    typedef logic [7:0]           byte_t;
    typedef logic [3:0]           digit_t;
    typedef logic [POS_WIDTH-1:0] pos_t;

    // Letter class of a byte
    typedef enum logic [1:0] {
        CLS_NONE     = 2'd0,
        CLS_LATIN    = 2'd1,
        CLS_CYRILLIC = 2'd2
    } letter_class_t;

    function automatic letter_class_t byte_class(input byte_t b);
        letter_class_t cls;
        cls = CLS_NONE;
        // A-Z and a-z: 0x41-0x5A / 0x61-0x7A, low five bits 1..26
        if (b[7:6] == 2'b01 && b[4:0] != 5'd0 && b[4:0] <= LATIN_SPAN)
            cls = CLS_LATIN;
        // Windows-1251 letters fill 0xC0-0xFF
        else if (b[7:6] == 2'b11)
            cls = CLS_CYRILLIC;
        return cls;
    endfunction

    function automatic digit_t digit_at(input logic [KEY_WIDTH-1:0] key, input pos_t pos);
        digit_t d;
        d = '0;
        for (int k = 0; k < KEY_DIGITS_MAX; k++) begin
            if (pos == POS_WIDTH'(k))
                d = key[4*k +: 4];
        end
        return d;
    endfunction

endpackage

FILE: hw/rtl/gbc_shift.sv
// ============================================================================
// gbc_shift
// Rotates one letter byte by a key digit within its alphabet; other bytes
// pass unchanged.
// ============================================================================
module gbc_shift (
    input  gbc_pkg::byte_t         in_byte,
    input  gbc_pkg::letter_class_t cls,
    input  gbc_pkg::digit_t        digit,
    input  logic                   decrypt,
    output gbc_pkg::byte_t         out_byte
);
    import gbc_pkg::*;

    logic [4:0] lat_off;
    logic [5:0] lat_sum;
    logic [5:0] lat_rot;
    logic [4:0] cyr_rot;

    assign lat_off = in_byte[4:0] - 5'd1;

    always_comb begin
        if (decrypt) begin
            lat_sum = {1'b0, lat_off} - {2'b00, digit};
            // borrow out: wrap back into the alphabet
            lat_rot = lat_sum[5] ? lat_sum + {1'b0, LATIN_SPAN} : lat_sum;
            cyr_rot = in_byte[4:0] - {1'b0, digit};
        end else begin
            lat_sum = {1'b0, lat_off} + {2'b00, digit};
            lat_rot = (lat_sum >= {1'b0, LATIN_SPAN}) ? lat_sum - {1'b0, LATIN_SPAN} : lat_sum;
            cyr_rot = in_byte[4:0] + {1'b0, digit};
        end
    end

    always_comb begin
        unique case (cls)
            CLS_LATIN:    out_byte = {in_byte[7:5], lat_rot[4:0] + 5'd1};
            CLS_CYRILLIC: out_byte = {in_byte[7:5], cyr_rot};
            default:      out_byte = in_byte;
        endcase
    end

endmodule

FILE: hw/rtl/gronsfeld_byte_cipher_unit.sv
// ============================================================================
// gronsfeld_byte_cipher_unit
// Byte stream Gronsfeld cipher: letters are rotated by the current decimal
// key digit, the key position advances on letters only.
// ============================================================================
//
//  channel  | direction | ports
//  ---------+-----------+---------------------------------------------
//  s_       | in        | s_valid, s_ready, s_in_byte, s_in_last
//  m_       | out       | m_valid, m_ready, m_out_byte, m_out_last
//  cfg_     | in        | cfg_wr_en, cfg_addr, cfg_wdata (no read-back)
//
//  One byte per clock sustained while m_ready stays high.
//  The key position is updated at input acceptance from the byte class
//  alone, so consecutive bytes need no bubble.
//  Input register and result register form a two-deep pipeline; a stall on
//  m_ready holds both and drops s_ready once both are full.
//  Synchronous active-low reset clears valids, key position and configuration.
//
module gronsfeld_byte_cipher_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_wr_en,
    input  logic [gbc_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr,
    input  logic [gbc_pkg::KEY_WIDTH-1:0]        cfg_wdata,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  gbc_pkg::byte_t                       s_in_byte,
    input  logic                                 s_in_last,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output gbc_pkg::byte_t                       m_out_byte,
    output logic                                 m_out_last
);
    import gbc_pkg::*;

    // configuration
    logic                   decrypt_reg;
    logic [KEY_WIDTH-1:0]   key_digits_reg;
    logic [LEN_WIDTH-1:0]   key_length_reg;

    // key position
    pos_t                   key_pos_reg;
    pos_t                   key_pos_next;

    // input stage
    logic                   s1_valid_reg;
    byte_t                  s1_byte_reg;
    logic                   s1_last_reg;
    pos_t                   s1_pos_reg;

    // result stage
    logic                   m_valid_reg;
    byte_t                  m_byte_reg;
    logic                   m_last_reg;

    logic                   s_accept;
    logic                   s1_advance;
    logic                   m_free;
    logic [LEN_WIDTH-1:0]   len_eff;
    pos_t                   pos_use;
    pos_t                   pos_inc;
    letter_class_t          in_cls;
    letter_class_t          s1_cls;
    digit_t                 s1_digit;
    byte_t                  s1_result;

    assign m_free     = !m_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && m_free;
    assign s_ready    = !s1_valid_reg || m_free;
    assign s_accept   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decrypt_reg    <= 1'b0;
            key_digits_reg <= '0;
            key_length_reg <= KEY_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_DECRYPT_MODE: decrypt_reg    <= cfg_wdata[0];
                CFG_KEY_DIGITS:   key_digits_reg <= cfg_wdata;
                CFG_KEY_LENGTH:   key_length_reg <= cfg_wdata[LEN_WIDTH-1:0];
                default:          ; // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Key position, resolved at acceptance
    // ------------------------------------------------------------------
    always_comb begin
        priority if (key_length_reg == '0)
            len_eff = LEN_WIDTH'(1);
        else if (key_length_reg > KEY_LENGTH_MAX)
            len_eff = KEY_LENGTH_MAX;
        else
            len_eff = key_length_reg;
    end

    assign in_cls  = byte_class(s_in_byte);
    assign pos_use = (key_pos_reg >= len_eff) ? '0 : key_pos_reg;
    assign pos_inc = pos_use + POS_WIDTH'(1);

    always_comb begin
        key_pos_next = pos_use;
        if (in_cls != CLS_NONE)
            key_pos_next = (pos_inc >= len_eff) ? '0 : pos_inc;
        if (s_in_last)
            key_pos_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            key_pos_reg <= '0;
        else if (s_accept)
            key_pos_reg <= key_pos_next;
    end

    // ------------------------------------------------------------------
    // Input stage
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn)
            s1_valid_reg <= 1'b0;
        else if (s_ready)
            s1_valid_reg <= s_valid;
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_byte_reg <= s_in_byte;
            s1_last_reg <= s_in_last;
            s1_pos_reg  <= pos_use;
        end
    end

    // ------------------------------------------------------------------
    // Letter rotation
    // ------------------------------------------------------------------
    assign s1_cls   = byte_class(s1_byte_reg);
    assign s1_digit = digit_at(key_digits_reg, s1_pos_reg);

    gbc_shift u_shift (
        .in_byte  (s1_byte_reg),
        .cls      (s1_cls),
        .digit    (s1_digit),
        .decrypt  (decrypt_reg),
        .out_byte (s1_result)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid_reg <= 1'b0;
        else if (m_free)
            m_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_byte_reg <= s1_result;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_out_last = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        key_pos_reg < POS_WIDTH'(KEY_DIGITS_MAX))
        else $error("key position beyond key register");

    a_last_clears_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_in_last) |=> (key_pos_reg == '0))
        else $error("key position not cleared after last byte");

    a_nonletter_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_advance && s1_cls == CLS_NONE) |=> (m_out_byte == $past(s1_byte_reg)))
        else $error("non-letter byte modified");

    a_letter_class_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_advance && s1_cls != CLS_NONE) |=> (byte_class(m_out_byte) == $past(s1_cls)))
        else $error("letter rotated out of its alphabet");

    a_pos_stable_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(key_pos_reg))
        else $error("key position moved without a transaction");

endmodule

FILE: tb/gronsfeld_byte_cipher_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// gronsfeld_byte_cipher_unit_tb
// Drives byte transactions through the cipher unit under random idling and
// back-pressure, with several key, length and direction settings. Expected
// bytes come from a cycle-free model of the key position and letter rings;
// each result transaction is compared with the oldest expected byte.
// ============================================================================
module gronsfeld_byte_cipher_unit_tb;

    import gbc_pkg::*;

    // Unused register index: writes to it must be ignored
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_NO_REG = 2'd3;

    localparam byte_t LATIN_UC_LO = 8'h41;
    localparam byte_t LATIN_UC_HI = 8'h5A;
    localparam byte_t LATIN_LC_LO = 8'h61;
    localparam byte_t LATIN_LC_HI = 8'h7A;
    localparam byte_t CYR_UC_LO   = 8'hC0;
    localparam byte_t CYR_UC_HI   = 8'hDF;
    localparam byte_t CYR_LC_LO   = 8'hE0;

    typedef struct packed {
        byte_t data;
        logic  last;
    } cipher_out_t;

    logic                       aclk;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0]  cfg_addr = '0;
    logic [KEY_WIDTH-1:0]       cfg_wdata = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    byte_t                      s_in_byte = '0;
    logic                       s_in_last = 1'b0;
    logic                       m_valid;
    logic                       m_ready;
    byte_t                      m_out_byte;
    logic                       m_out_last;

    // Mirror of the unit's configuration and key position
    logic                       mode_decrypt = 1'b0;
    logic [KEY_WIDTH-1:0]       key_bcd = '0;
    logic [LEN_WIDTH-1:0]       key_len = KEY_LENGTH_RESET;
    pos_t                       key_pos = '0;

    cipher_out_t                expected_bytes[$];
    cipher_out_t                head;
    int unsigned                mismatch_count = 0;
    int unsigned                bytes_sent = 0;
    bit                         sender_gaps = 1'b1;
    bit                         receiver_gaps = 1'b1;
    int unsigned                hold_left = 0;

    gronsfeld_byte_cipher_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

    // Shift one byte by the current key digit and advance the key position
    function automatic byte_t gronsfeld_shift(input byte_t b, input logic last);
        int len, pos, base, span, d, v;
        byte_t res;
        len = int'(key_len);
        if (len == 0) len = 1;
        if (len > KEY_DIGITS_MAX) len = KEY_DIGITS_MAX;
        pos = int'(key_pos);
        if (pos >= len) pos = 0;
        span = 0;
        base = 0;
        res = b;
        if (b >= LATIN_UC_LO && b <= LATIN_UC_HI) begin
            base = int'(LATIN_UC_LO); span = 26;
        end else if (b >= LATIN_LC_LO && b <= LATIN_LC_HI) begin
            base = int'(LATIN_LC_LO); span = 26;
        end else if (b >= CYR_UC_LO && b <= CYR_UC_HI) begin
            base = int'(CYR_UC_LO); span = 32;
        end else if (b >= CYR_LC_LO) begin
            base = int'(CYR_LC_LO); span = 32;
        end
        if (span != 0) begin
            d = (pos < KEY_DIGITS_MAX) ? int'(key_bcd[4*pos +: 4]) : 0;
            v = int'(b) - base;
            v = mode_decrypt ? (2 * span + v - d) % span : (v + d) % span;
            res = byte_t'(base + v);
            pos++;
            if (pos >= len) pos = 0;
        end
        if (last) pos = 0;
        key_pos = pos_t'(pos);
        return res;
    endfunction

    // Receiver: random stalls, or a counted hold-off when requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (receiver_gaps) begin
                m_ready <= ($urandom_range(99) >= 20);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected transaction: expected none, got byte %h last %b",
                         $time, m_out_byte, m_out_last);
                mismatch_count++;
            end else begin
                head = expected_bytes.pop_front();
                if (m_out_byte !== head.data) begin
                    $display("%0t: out_byte mismatch: expected %h, got %h",
                             $time, head.data, m_out_byte);
                    mismatch_count++;
                end
                if (m_out_last !== head.last) begin
                    $display("%0t: out_last mismatch: expected %b, got %b",
                             $time, head.last, m_out_last);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_byte(input byte_t b, input logic last);
        cipher_out_t exp;
        @(negedge aclk);
        while (sender_gaps && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= last;
        do @(posedge aclk); while (!s_ready);
        exp.data = gronsfeld_shift(b, last);
        exp.last = last;
        expected_bytes.push_back(exp);
        bytes_sent++;
    endtask

    // Drop valid, wait out every expected byte, then the pipeline latency
    task automatic drain;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] addr,
                             input logic [KEY_WIDTH-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        case (addr)
            CFG_DECRYPT_MODE: mode_decrypt = data[0];
            CFG_KEY_DIGITS:   key_bcd = data;
            CFG_KEY_LENGTH:   key_len = data[LEN_WIDTH-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [KEY_WIDTH-1:0] random_word();
        return KEY_WIDTH'({$urandom(), $urandom()});
    endfunction

    function automatic logic [KEY_WIDTH-1:0] random_bcd_key();
        logic [KEY_WIDTH-1:0] k;
        k = '0;
        for (int i = 0; i < KEY_DIGITS_MAX; i++)
            k[4*i +: 4] = 4'($urandom_range(9));
        return k;
    endfunction

    // Mostly letters; noise draws from the whole byte range
    function automatic byte_t pick_byte(input bit noise);
        byte_t b;
        if (noise || $urandom_range(99) < 20)
            b = byte_t'($urandom_range(255));
        else begin
            case ($urandom_range(3))
                0: b = byte_t'($urandom_range(LATIN_UC_HI, LATIN_UC_LO));
                1: b = byte_t'($urandom_range(LATIN_LC_HI, LATIN_LC_LO));
                2: b = byte_t'($urandom_range(CYR_UC_HI, CYR_UC_LO));
                default: b = byte_t'($urandom_range(8'hFF, CYR_LC_LO));
            endcase
        end
        return b;
    endfunction

    task automatic send_message(input int n, input bit closed, input bit noise);
        for (int i = 0; i < n; i++)
            send_byte(pick_byte(noise), closed && (i == n - 1));
    endtask

    // Reset values: zero key, length one, so letters pass unchanged
    task automatic test_reset_defaults;
        send_byte("Q", 1'b0);
        send_byte(8'hE5, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();
    endtask

    task automatic test_field_extremes;
        byte_t edge_bytes[12] = '{8'h00, 8'hFF, 8'h41, 8'h5A, 8'h61, 8'h7A,
                                  8'h40, 8'h5B, 8'h60, 8'h7B, 8'hC0, 8'hDF};
        write_reg(CFG_KEY_DIGITS, 40'h9876543219);
        write_reg(CFG_KEY_LENGTH, 40'd10);
        foreach (edge_bytes[i])
            send_byte(edge_bytes[i], i == 11);
        drain();
        write_reg(CFG_DECRYPT_MODE, 40'd1);
        send_byte(8'h41, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h61, 1'b1);
        drain();
    endtask

    task automatic test_key_corners;
        // length zero acts as one
        write_reg(CFG_DECRYPT_MODE, 40'd0);
        write_reg(CFG_KEY_LENGTH, 40'd0);
        send_byte("a", 1'b0);
        send_byte("z", 1'b0);
        drain();
        // length above the maximum clamps; nibbles above nine shift as is
        write_reg(CFG_KEY_DIGITS, {KEY_WIDTH{1'b1}});
        write_reg(CFG_KEY_LENGTH, 40'd15);
        send_byte("Z", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hD0, 1'b1);
        drain();
        // lower the length under the current position mid-message
        write_reg(CFG_KEY_DIGITS, 40'h0987654321);
        write_reg(CFG_KEY_LENGTH, 40'd10);
        for (int i = 0; i < 5; i++)
            send_byte(byte_t'(LATIN_UC_LO + i), 1'b0);
        drain();
        write_reg(CFG_KEY_LENGTH, 40'd3);
        write_reg(CFG_NO_REG, {KEY_WIDTH{1'b1}});
        send_byte("m", 1'b0);
        send_byte("n", 1'b1);
        drain();
    endtask

    // Random settings per phase, extremes first in rotation
    task automatic test_random_messages(input int phases, input int per_phase);
        int start;
        for (int p = 0; p < phases; p++) begin
            drain();
            sender_gaps   = (p != 4);
            receiver_gaps = (p != 4);
            case (p % 5)
                0: write_reg(CFG_KEY_DIGITS, '0);
                1: write_reg(CFG_KEY_DIGITS, 40'h9999999999);
                2: write_reg(CFG_KEY_DIGITS, random_word());
                default: write_reg(CFG_KEY_DIGITS, random_bcd_key());
            endcase
            case (p % 6)
                0: write_reg(CFG_KEY_LENGTH, random_word() & ~40'hF);
                1: write_reg(CFG_KEY_LENGTH, 40'd1);
                2: write_reg(CFG_KEY_LENGTH, 40'd10);
                3: write_reg(CFG_KEY_LENGTH, 40'd15);
                default: write_reg(CFG_KEY_LENGTH, random_word());
            endcase
            write_reg(CFG_DECRYPT_MODE, random_word());
            start = bytes_sent;
            while (bytes_sent - start < per_phase)
                send_message($urandom_range(20, 1), $urandom_range(9) != 0,
                             $urandom_range(3) == 0);
        end
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        drain();
    endtask

    // Hold the result side long enough for the unit to fill and stall input
    task automatic test_output_hold;
        write_reg(CFG_KEY_DIGITS, random_bcd_key());
        write_reg(CFG_KEY_LENGTH, 40'd7);
        hold_left = 300;
        send_message(40, 1'b1, 1'b0);
        send_message(60, 1'b0, 1'b0);
        hold_left = 150;
        send_message(20, 1'b1, 1'b1);
        drain();
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_field_extremes();
        test_key_corners();
        test_output_hold();
        test_random_messages(12, 150);
        repeat (10) @(negedge aclk);
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
